/* sv/pfd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and codes of the pressure frame decoder.
package pfd_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int BYTE_IDX_W  = 4;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Byte positions inside one reply frame.
    localparam logic [BYTE_IDX_W-1:0] IDX_P_HI   = BYTE_IDX_W'(0);
    localparam logic [BYTE_IDX_W-1:0] IDX_P_LO   = BYTE_IDX_W'(1);
    localparam logic [BYTE_IDX_W-1:0] IDX_P_CRC  = BYTE_IDX_W'(2);
    localparam logic [BYTE_IDX_W-1:0] IDX_S_HI   = BYTE_IDX_W'(6);
    localparam logic [BYTE_IDX_W-1:0] IDX_S_LO   = BYTE_IDX_W'(7);
    localparam logic [BYTE_IDX_W-1:0] IDX_S_CRC  = BYTE_IDX_W'(8);
    localparam logic [BYTE_IDX_W-1:0] IDX_LAST   = BYTE_IDX_W'(FRAME_BYTES - 1);

    localparam logic CMD_BYTE     = 1'b0;
    localparam logic CMD_BUS_FAIL = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_DELTA = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_AFTER  = CFG_IDX_W'(1);

    localparam logic [15:0] DELTA_RESET = 16'd10;
    localparam logic [7:0]  FAULT_RESET = 8'd3;
    localparam logic [7:0]  STREAK_MAX  = 8'hFF;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CRC   = 2'd1,
        ST_SCALE = 2'd2,
        ST_BUS   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic       cmd;
        logic [7:0] frame_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] pressure_pa;
        logic [14:0]        failsafe_pa;
        logic               report;
        logic               sensor_fault;
        logic [7:0]         error_streak;
    } t_out_item;

    // A classified sample on its way from the front to the back.
    typedef struct packed {
        t_status     status;
        logic [15:0] pressure_word;
        logic [14:0] scale;
    } t_job;

endpackage

/* sv/pfd_front.sv */
`timescale 1ns / 1ps
// Front end: takes reply bytes and bus-fail commands, runs the CRC and classifies each finished sample.
module pfd_front import pfd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic     i_queue_full,
    output logic     o_job_push,
    output t_job     o_job
);

    logic [BYTE_IDX_W-1:0] r_byte_idx, n_byte_idx;
    logic [7:0]            r_crc, n_crc;
    logic                  r_crc_bad, n_crc_bad;
    logic [15:0]           r_pres_word, n_pres_word;
    logic [15:0]           r_scale_word, n_scale_word;

    logic       accept;
    logic [7:0] crc_next;
    logic [7:0] b;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    assign accept   = i_in_valid && !i_queue_full;
    assign b        = i_in_item.frame_byte;
    assign crc_next = crc8_byte(r_crc, b);

    always_comb begin
        n_byte_idx   = r_byte_idx;
        n_crc        = r_crc;
        n_crc_bad    = r_crc_bad;
        n_pres_word  = r_pres_word;
        n_scale_word = r_scale_word;
        o_job_push   = 1'b0;
        o_job.status        = ST_OK;
        o_job.pressure_word = r_pres_word;
        o_job.scale         = r_scale_word[14:0];

        if (accept) begin
            if (i_in_item.cmd == CMD_BUS_FAIL) begin
                n_byte_idx   = '0;
                n_crc        = CRC_INIT;
                n_crc_bad    = 1'b0;
                o_job_push   = 1'b1;
                o_job.status = ST_BUS;
            end else begin
                case (r_byte_idx)
                    IDX_P_HI: n_pres_word[15:8]  = b;
                    IDX_P_LO: n_pres_word[7:0]   = b;
                    IDX_S_HI: n_scale_word[15:8] = b;
                    IDX_S_LO: n_scale_word[7:0]  = b;
                    default: ;
                endcase

                if (r_byte_idx inside {IDX_P_HI, IDX_P_LO, IDX_S_HI, IDX_S_LO}) begin
                    n_crc = crc_next;
                end
                if (r_byte_idx inside {IDX_P_CRC, IDX_S_CRC}) begin
                    if (r_crc != b) begin
                        n_crc_bad = 1'b1;
                    end
                    n_crc = CRC_INIT;
                end

                if (r_byte_idx == IDX_LAST) begin
                    o_job_push = 1'b1;
                    if (n_crc_bad) begin
                        o_job.status = ST_CRC;
                    end else if (r_scale_word[15] || (r_scale_word == 16'd0)) begin
                        o_job.status = ST_SCALE;
                    end else begin
                        o_job.status = ST_OK;
                    end
                    n_byte_idx = '0;
                    n_crc      = CRC_INIT;
                    n_crc_bad  = 1'b0;
                end else begin
                    n_byte_idx = r_byte_idx + BYTE_IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx   <= '0;
            r_crc        <= CRC_INIT;
            r_crc_bad    <= 1'b0;
            r_pres_word  <= '0;
            r_scale_word <= '0;
        end else begin
            r_byte_idx   <= n_byte_idx;
            r_crc        <= n_crc;
            r_crc_bad    <= n_crc_bad;
            r_pres_word  <= n_pres_word;
            r_scale_word <= n_scale_word;
        end
    end

endmodule

/* sv/pfd_queue.sv */
`timescale 1ns / 1ps
// Short job queue between the front end and the back end.
module pfd_queue import pfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job                   r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QUEUE_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + QUEUE_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QUEUE_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* sv/pfd_back.sv */
`timescale 1ns / 1ps
// Back end: divider, error streak, report decision and the result register.
module pfd_back import pfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  t_job                  i_job,
    output logic                  o_job_pop,
    input  logic                  i_cfg_write,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    t_back_state r_state, n_state;

    logic [15:0]          r_quo;
    logic [14:0]          r_rem;
    logic [14:0]          r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic [15:0]          r_pa;
    logic [7:0]           r_fail_cnt;
    logic [15:0]          r_last_rep;
    logic                 r_rep_valid;
    logic [15:0]          r_delta;
    logic [7:0]           r_fault_lim;
    t_out_item            r_out;
    logic                 r_out_valid;

    logic        slot_free;
    logic        load;
    logic        emit;
    t_out_item   n_item;
    logic [7:0]  n_fail_cnt;
    logic [15:0] mag;
    logic [15:0] trial;
    logic [16:0] diff;
    logic [16:0] abs_diff;

    assign slot_free = !r_out_valid || !i_out_stall;

    assign mag   = i_job.pressure_word[15] ? (16'd0 - i_job.pressure_word)
                                           : i_job.pressure_word;
    assign trial = {r_rem, r_quo[15]};

    assign diff     = {r_pa[15], r_pa} - {r_last_rep[15], r_last_rep};
    assign abs_diff = diff[16] ? (17'd0 - diff) : diff;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid && (i_job.status == ST_OK)) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = BK_SIGN;
                end
            end
            BK_SIGN: n_state = BK_DONE;
            BK_DONE: begin
                if (slot_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop  = 1'b0;
        load       = 1'b0;
        emit       = 1'b0;
        n_fail_cnt = (r_fail_cnt == STREAK_MAX) ? r_fail_cnt : r_fail_cnt + 8'd1;
        n_item.status      = ST_OK;
        n_item.pressure_pa = '0;
        n_item.failsafe_pa = '0;
        n_item.report      = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.status == ST_OK) begin
                        o_job_pop = 1'b1;
                        load      = 1'b1;
                    end else if (slot_free) begin
                        o_job_pop     = 1'b1;
                        emit          = 1'b1;
                        n_item.status = i_job.status;
                    end
                end
            end
            BK_DONE: begin
                emit               = slot_free;
                n_fail_cnt         = 8'd0;
                n_item.pressure_pa = r_pa;
                n_item.failsafe_pa = (!r_pa[15] && (r_pa != 16'd0)) ? r_pa[14:0] : 15'd0;
                n_item.report      = !r_rep_valid || (abs_diff >= {1'b0, r_delta});
            end
            default: ;
        endcase
        n_item.error_streak = n_fail_cnt;
        n_item.sensor_fault = (n_fail_cnt >= r_fault_lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cnt       <= '0;
            r_fail_cnt  <= '0;
            r_last_rep  <= '0;
            r_rep_valid <= 1'b0;
            r_delta     <= DELTA_RESET;
            r_fault_lim <= FAULT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_write) begin
                if (i_cfg_index == CFG_REPORT_DELTA) begin
                    r_delta <= i_cfg_data;
                end else if (i_cfg_index == CFG_FAULT_AFTER) begin
                    r_fault_lim <= i_cfg_data[7:0];
                end
            end

            if (load) begin
                r_cnt <= '0;
            end else if (r_state == BK_DIV) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end

            if (emit) begin
                r_out_valid <= 1'b1;
                r_fail_cnt  <= n_fail_cnt;
                if ((r_state == BK_DONE) && n_item.report) begin
                    r_last_rep  <= r_pa;
                    r_rep_valid <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Divider datapath: restoring, one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_neg <= i_job.pressure_word[15];
            r_quo <= mag + {2'b00, i_job.scale[14:1]};
            r_rem <= '0;
            r_div <= i_job.scale;
        end else if (r_state == BK_DIV) begin
            if (trial >= {1'b0, r_div}) begin
                r_rem <= 15'(trial - {1'b0, r_div});
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= trial[14:0];
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
        if (r_state == BK_SIGN) begin
            r_pa <= r_neg ? (16'd0 - r_quo) : r_quo;
        end
        if (emit) begin
            r_out <= n_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> (r_div != 15'd0))
        else $error("divider running with a zero divisor");

    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> i_job_valid)
        else $error("job popped from an empty queue");

    a_report_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (r_state == BK_DONE) && n_item.report) |=> r_rep_valid)
        else $error("reported reading not remembered");

    a_error_streak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (n_item.status != ST_OK)) |-> (n_item.error_streak != 8'd0))
        else $error("failed sample left the error streak at zero");
`endif

endmodule

/* sv/pressure_frame_decoder.sv */
`timescale 1ns / 1ps
// Top level of the pressure frame decoder: front end, job queue and back end.
//
//   Channel | Direction | Handshake              | Payload
//   in      | input     | i_in_valid / o_in_stall   | i_in_item (cmd, frame_byte)
//   out     | output    | o_out_valid / i_out_stall | o_out_item (status .. error_streak)
//   cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// The front end takes one byte a cycle; the input stalls only while the two-entry queue is full.
// A failed sample goes from the queue head straight into the result register once that register is free.
// A good sample runs through the 16-step bit-serial divider and the sign step, then waits for the result register.
// A finished result waits in the output register while the next good job can already be dequeued.
// Reset is synchronous and active low; configuration writes are taken in every cycle.
module pressure_frame_decoder import pfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic queue_full;
    logic job_push;
    t_job push_job;
    logic job_valid;
    t_job head_job;
    logic job_pop;

    assign o_in_stall  = queue_full;
    assign o_cfg_ready = 1'b1;

    pfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_queue_full (queue_full),
        .o_job_push   (job_push),
        .o_job        (push_job)
    );

    pfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (push_job),
        .o_full  (queue_full),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    pfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_job_pop   (job_pop),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
